FILE: rtl/csr_spike_current_scatter_macros.svh
// Assertion helpers
`ifndef CSR_SPIKE_CURRENT_SCATTER_MACROS_SVH
`define CSR_SPIKE_CURRENT_SCATTER_MACROS_SVH
`define CSC_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error("lbl");
`define CSC_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error("lbl");
`endif

FILE: rtl/csc_pkg.sv
package csc_pkg;
  typedef enum logic [2:0] {
    REQ_ROW   = 3'd0,
    REQ_ENTRY = 3'd1,
    REQ_WEIGHT = 3'd2,
    REQ_BASIS = 3'd3,
    REQ_CLEAR = 3'd4,
    REQ_SPIKE = 3'd5,
    REQ_READ  = 3'd6,
    REQ_NOP   = 3'd7
  } req_t;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  // one accumulate step for the shared unit
  typedef struct packed {
    logic        go;
    logic [31:0] acc;
    logic [31:0] ws;
    logic [15:0] basis;
  } mac_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] sum;
    logic        sat;
  } mac_rsp_t;
endpackage

FILE: rtl/csr_spike_current_scatter.sv
// A spike event scatters each good row entry through the shared MAC, one pass
//   per basis, and skips bad entries; a clear item zeroes the whole current store.
// Throughput: one item at a time; the next transfer is taken the cycle after
//   the result transfer.
// Reset: synchronous active-low; afterwards a clearing pass zeroes all
//   N_BATCH*N_POST*N_BASIS entries of the current store, no item taken.
`include "csr_spike_current_scatter_macros.svh"
module csr_spike_current_scatter
  import csc_pkg::*;
#(
  parameter int N_PRE   = 1024,
  parameter int N_POST  = 1024,
  parameter int N_EDGES = 16384,
  parameter int N_TYPES = 16,
  parameter int N_BASIS = 4,
  parameter int N_BATCH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // req_type[2:0] index[16:3] row_start[31:17] edge_req[45:32] post[55:46]
  // syn_type[59:56] weight[75:60] basis_value[91:76] receptor[93:92]
  // batch[95:94] pre[105:96] spike[121:106], zero fill to 128
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // current_value[31:0] status[33:32], zero fill to 40
  output logic [39:0]  out_tdata
);
  localparam int RW = $clog2(N_PRE + 2);
  localparam int EW = $clog2(N_EDGES + 1);
  localparam int EA = (N_EDGES > 1) ? $clog2(N_EDGES) : 1;
  localparam int BW = (N_BASIS > 1) ? $clog2(N_BASIS) : 1;
  localparam int SW = (N_BATCH > 1) ? $clog2(N_BATCH) : 1;
  localparam int CD = N_BATCH * N_POST * N_BASIS;
  localparam int CW = (CD > 1) ? $clog2(CD) : 1;
  localparam int BD = N_TYPES * N_BASIS;
  localparam int BAW = (BD > 1) ? $clog2(BD) : 1;

  logic [2:0]  f_req;
  logic [13:0] f_idx, f_edge;
  logic [14:0] f_rs;
  logic [9:0]  f_post, f_pre;
  logic [3:0]  f_ty;
  logic [15:0] f_w, f_bv, f_spk;
  logic [1:0]  f_rec, f_b;
  assign f_req  = in_tdata[2:0];
  assign f_idx  = in_tdata[16:3];
  assign f_rs   = in_tdata[31:17];
  assign f_edge = in_tdata[45:32];
  assign f_post = in_tdata[55:46];
  assign f_ty   = in_tdata[59:56];
  assign f_w    = in_tdata[75:60];
  assign f_bv   = in_tdata[91:76];
  assign f_rec  = in_tdata[93:92];
  assign f_b    = in_tdata[95:94];
  assign f_pre  = in_tdata[105:96];
  assign f_spk  = in_tdata[121:106];

  logic [14:0] row_mem [N_PRE+1];
  logic [27:0] ent_mem [N_EDGES];
  logic [15:0] w_mem   [N_EDGES];
  logic [15:0] bas_mem [BD];
  logic [31:0] cur_mem [CD];

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_ROW0, S_ROW1, S_ROWCHK, S_ENT, S_ENTCHK, S_WT,
    S_WS, S_BAS, S_MAC, S_WB, S_OUT
  } state_t;
  state_t state_r;

  logic [CW-1:0]  clr_r;
  logic           clr_item_r;
  logic [SW-1:0]  b_r;
  logic [15:0]    spk_r;
  logic [EW:0]    a_r, end_r;
  logic [14:0]    rdat_r;
  logic [27:0]    edat_r;
  logic [15:0]    wdat_r, bdat_r;
  logic [31:0]    cdat_r, ws_r, val_r;
  logic [BW-1:0]  r_r;
  logic [1:0]     st_r;
  logic           sat_r, ready_r;
  logic [RW-1:0]  raddr_r;
  logic [EA-1:0]  eaddr_r, waddr_r;
  logic [BAW-1:0] baddr_r;
  logic [CW-1:0]  caddr_r, cbase_r;
  logic           cwe_r;
  logic [CW-1:0]  cwa_r;
  logic [31:0]    cwd_r;
  mac_req_t       mreq;
  mac_rsp_t       mrsp;

  always_ff @(posedge clk) begin
    rdat_r <= row_mem[raddr_r];
    edat_r <= ent_mem[eaddr_r];
    wdat_r <= w_mem[waddr_r];
    bdat_r <= bas_mem[baddr_r];
    cdat_r <= cur_mem[caddr_r];
    if (cwe_r) cur_mem[cwa_r] <= cwd_r;
    if (in_tvalid && in_tready) begin
      case (req_t'(f_req))
        REQ_ROW:    if (32'(f_idx) <= N_PRE) row_mem[RW'(f_idx)] <= f_rs;
        REQ_ENTRY:  if (32'(f_idx) < N_EDGES)
                      ent_mem[EA'(f_idx)] <= {f_ty, f_post, f_edge};
        REQ_WEIGHT: if (32'(f_idx) < N_EDGES) w_mem[EA'(f_idx)] <= f_w;
        REQ_BASIS:  if (32'(f_ty) < N_TYPES && 32'(f_rec) < N_BASIS)
                      bas_mem[BAW'(32'(f_ty) * N_BASIS + 32'(f_rec))] <= f_bv;
        default: ;
      endcase
    end
  end

  csc_mac u_mac (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));
  assign mreq.ws = ws_r;
  assign mreq.basis = bdat_r;
  assign mreq.acc = cdat_r;
  assign mreq.go = (state_r == S_MAC) && !ready_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {6'd0, st_r, val_r};

  logic [9:0]  e_post;
  logic [3:0]  e_ty;
  logic [13:0] e_edge;
  assign {e_ty, e_post, e_edge} = edat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      clr_r      <= '0;
      clr_item_r <= 1'b0;
      ready_r    <= 1'b0;
      cwe_r      <= 1'b0;
    end else begin
      cwe_r <= (state_r == S_CLR) || ((state_r == S_MAC) && ready_r && mrsp.done);
      case (state_r)
        S_CLR: begin
          cwa_r <= clr_r; cwd_r <= '0;
          if (32'(clr_r) == CD - 1) begin
            clr_r <= '0;
            state_r <= clr_item_r ? S_OUT : S_IDLE;
          end else begin
            clr_r <= clr_r + 1'b1;
          end
        end
        S_IDLE: if (in_tvalid) begin
          val_r <= '0; st_r <= ST_OK; sat_r <= 1'b0;
          b_r <= SW'(f_b); spk_r <= f_spk;
          case (req_t'(f_req))
            REQ_CLEAR: begin
              clr_item_r <= 1'b1; state_r <= S_CLR;
            end
            REQ_SPIKE: begin
              if (32'(f_b) >= N_BATCH || 32'(f_pre) >= N_PRE) begin
                st_r <= ST_BAD; state_r <= S_OUT;
              end else begin
                raddr_r <= RW'(f_pre); state_r <= S_ROW0;
              end
            end
            REQ_READ: begin
              if (32'(f_b) < N_BATCH && 32'(f_post) < N_POST &&
                  32'(f_rec) < N_BASIS) begin
                caddr_r <= CW'((32'(f_b) * N_POST + 32'(f_post)) * N_BASIS
                               + 32'(f_rec));
                ready_r <= 1'b0;
                state_r <= S_RD;
              end else state_r <= S_OUT;
            end
            default: state_r <= S_OUT;
          endcase
        end
        S_RD: begin
          ready_r <= 1'b1;
          if (ready_r) begin val_r <= cdat_r; state_r <= S_OUT; end
        end
        S_ROW0: begin
          raddr_r <= raddr_r + 1'b1; state_r <= S_ROW1; ready_r <= 1'b0;
        end
        S_ROW1: begin
          // start lands now, end next cycle
          if (ready_r) begin
            end_r <= (EW+1)'(rdat_r); state_r <= S_ROWCHK;
          end else begin
            a_r <= (EW+1)'(rdat_r); ready_r <= 1'b1;
          end
        end
        S_ROWCHK: begin
          if (a_r > end_r || 32'(end_r) > N_EDGES) begin
            st_r <= ST_BAD; state_r <= S_OUT;
          end else if (a_r == end_r) state_r <= S_OUT;
          else begin eaddr_r <= EA'(a_r); ready_r <= 1'b0; state_r <= S_ENT; end
        end
        S_ENT: begin
          ready_r <= 1'b1;
          if (ready_r) state_r <= S_ENTCHK;
        end
        S_ENTCHK: begin
          if (32'(e_edge) >= N_EDGES || 32'(e_post) >= N_POST ||
              32'(e_ty) >= N_TYPES) begin
            a_r <= a_r + 1'b1;
            state_r <= S_WB;
          end else begin
            waddr_r <= EA'(e_edge);
            cbase_r <= CW'((32'(b_r) * N_POST + 32'(e_post)) * N_BASIS);
            r_r <= '0; ready_r <= 1'b0; state_r <= S_WT;
          end
        end
        S_WT: begin
          ready_r <= 1'b1;
          if (ready_r) state_r <= S_WS;
        end
        S_WS: begin
          ws_r <= 32'($signed(spk_r)) * 32'($signed(wdat_r));
          state_r <= S_BAS;
          ready_r <= 1'b0;
        end
        S_BAS: begin
          baddr_r <= BAW'(32'(e_ty) * N_BASIS + 32'(r_r));
          caddr_r <= cbase_r + CW'(r_r);
          if (ready_r) begin ready_r <= 1'b0; state_r <= S_MAC; end
          else ready_r <= 1'b1;
        end
        S_MAC: begin
          // issue on the first cycle, then wait for the unit
          if (!ready_r) ready_r <= 1'b1;
          else if (mrsp.done) begin
            cwa_r <= caddr_r; cwd_r <= mrsp.sum;
            if (mrsp.sat) sat_r <= 1'b1;
            ready_r <= 1'b0;
            if (32'(r_r) == N_BASIS - 1) begin
              a_r <= a_r + 1'b1; state_r <= S_WB;
            end else begin
              r_r <= r_r + 1'b1; state_r <= S_BAS;
            end
          end
        end
        S_WB: begin
          if (a_r == end_r) begin
            st_r <= sat_r ? ST_SAT : ST_OK; state_r <= S_OUT;
          end else begin
            eaddr_r <= EA'(a_r); ready_r <= 1'b0; state_r <= S_ENT;
          end
        end
        S_OUT: if (out_tready) begin
          clr_item_r <= 1'b0; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `CSC_ASSERT_IMP(a_busy_no_take, clk, rst_n, state_r != S_IDLE, !in_tready)
  `CSC_ASSERT_IMP(a_st_range, clk, rst_n, out_tvalid, out_tdata[33:32] != 2'd3)
  `CSC_ASSERT_NXT(a_out_done, clk, rst_n, out_tvalid && out_tready, in_tready)
endmodule

FILE: rtl/csc_mac.sv
// Shared multiply/round/saturating-add unit, pipelined through the operand, product and sum registers.
module csc_mac
  import csc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mac_req_t req,
  output mac_rsp_t rsp
);
  logic [2:0]         vld_r;
  logic signed [31:0] ws_r;
  logic signed [15:0] bas_r;
  logic signed [31:0] acc_r, acc2_r;
  logic signed [47:0] prod_r;
  logic signed [24:0] term_nxt;
  logic signed [33:0] sum_nxt;
  logic [31:0]        sum_r;
  logic               sat_r;

  always_comb begin
    term_nxt = 25'((prod_r + 48'sd8388608) >>> 24);
    sum_nxt  = 34'(acc2_r) + 34'(term_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], req.go};
    end
    ws_r   <= req.ws;
    bas_r  <= req.basis;
    acc_r  <= req.acc;
    prod_r <= ws_r * bas_r;
    acc2_r <= acc_r;
    if (sum_nxt > 34'sh7FFFFFFF) begin
      sum_r <= 32'h7FFFFFFF; sat_r <= 1'b1;
    end else if (sum_nxt < -34'sh80000000) begin
      sum_r <= 32'h80000000; sat_r <= 1'b1;
    end else begin
      sum_r <= sum_nxt[31:0]; sat_r <= 1'b0;
    end
  end

  assign rsp.done = vld_r[2];
  assign rsp.sum  = sum_r;
  assign rsp.sat  = sat_r;
endmodule
